// ===== hw/rtl/mac_grid_divergence_curl_assert.svh =====
// ----------------------------------------------------------------------------
// mac_grid_divergence_curl_assert.svh
// Assertion macros shared by the checker of the MAC grid block.
// ----------------------------------------------------------------------------
`ifndef MAC_GRID_DIVERGENCE_CURL_ASSERT_SVH
`define MAC_GRID_DIVERGENCE_CURL_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define MGDC_CHK_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mgdc check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define MGDC_CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mgdc check failed");

`endif

// ===== hw/rtl/mgdc_pkg.sv =====
// ----------------------------------------------------------------------------
// mgdc_pkg
// Types, constants and helpers of the MAC grid divergence/curl block.
// ----------------------------------------------------------------------------
package mgdc_pkg;

  // Grid and field geometry
  localparam int MAX_RES     = 64;
  localparam int VALUE_W     = 32;
  localparam int IDX_W       = 7;
  localparam int KIND_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int U_STRIDE    = MAX_RES + 1;
  localparam int V_STRIDE    = MAX_RES;
  localparam int STORE_DEPTH = (MAX_RES + 1) * MAX_RES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Arithmetic widths
  localparam int HALF_W      = 16;
  localparam int DIFF_W      = VALUE_W + 3;
  localparam int MUL_W       = DIFF_W + HALF_W;
  localparam int PROD_W      = MUL_W + 1;
  localparam int ACC_W       = PROD_W + 2;
  localparam int CURL_EXTRA  = 2;
  localparam int SCALE_DEPTH = 3;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_WR_U  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WR_V  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RES_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_X   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Y   = 2'd3;

  // Face read steps of one query
  localparam logic [2:0] STEP_BASE  = 3'd0;
  localparam logic [2:0] STEP_NEXT  = 3'd1;
  localparam logic [2:0] STEP_HI_A  = 3'd2;
  localparam logic [2:0] STEP_HI_B  = 3'd3;
  localparam logic [2:0] STEP_LO_A  = 3'd4;
  localparam logic [2:0] STEP_LO_B  = 3'd5;

  // Scaled terms of one query
  localparam logic [1:0] TERM_DIV_X  = 2'd0;
  localparam logic [1:0] TERM_DIV_Y  = 2'd1;
  localparam logic [1:0] TERM_CURL_X = 2'd2;
  localparam logic [1:0] TERM_CURL_Y = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_SETTLE,
    ST_SCALE,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       wr_u;
    logic       wr_v;
    logic       q_latch;
    logic       rd_en;
    logic [2:0] rd_step;
    logic       sc_en;
    logic [1:0] sc_term;
    logic       out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic q_err;
  } status_t;

  // Clip a wide signed sum to the result width
  function automatic logic signed [VALUE_W-1:0] sat_val(input logic signed [ACC_W-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[ACC_W-1:VALUE_W-1];
    all_zero = ~(|v[ACC_W-1:VALUE_W-1]);
    if (all_one || all_zero) begin
      return v[VALUE_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VALUE_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== hw/rtl/mac_grid_divergence_curl.sv =====
// ----------------------------------------------------------------------------
// mac_grid_divergence_curl
// 2D staggered velocity grid with per-cell divergence and curl queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input: an item is taken on a clock edge with start high and busy low.
//   in_kind selects a u-face write, a v-face write or a cell query.
//   Writes finish in the accept cycle and keep busy low, so one write can
//   be taken every cycle. Writes outside the store are dropped.
//   A query raises busy through a range check, six reads of the two
//   single-port face stores (one u and one v face per cycle), a settle
//   step, four scaled terms through the three-stage multiplier, a drain
//   of the multiplier and a result load. The result beat shows on
//   out_* with out_valid high for one cycle, right after busy drops; that
//   same cycle can accept the next item. No new item is taken while a query
//   runs; one outside the resolution goes from the range check to the result load.
//   The receiver cannot stall, so there is no hold-off on out_valid.
//   Config: write cfg_index/cfg_data with cfg_valid while idle; cfg_ready
//   stays high. Reset restores 64 x 64 cells and unit spacing; the face
//   stores are not cleared and must be written before they are queried.
// ----------------------------------------------------------------------------
module mac_grid_divergence_curl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic        [mgdc_pkg::KIND_W-1:0]   in_kind,
  input  logic        [mgdc_pkg::IDX_W-1:0]    in_col,
  input  logic        [mgdc_pkg::IDX_W-1:0]    in_row,
  input  logic signed [mgdc_pkg::VALUE_W-1:0]  in_face_value,
  output logic                                 out_valid,
  output logic signed [mgdc_pkg::VALUE_W-1:0]  out_divergence,
  output logic signed [mgdc_pkg::VALUE_W-1:0]  out_curl,
  output logic                                 out_index_error,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [mgdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [31:0]                   cfg_data
);
  import mgdc_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    cfg_we;

  // Register writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  mgdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_kind   (in_kind),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  mgdc_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_col          (in_col),
    .in_row          (in_row),
    .in_face_value   (in_face_value),
    .out_divergence  (out_divergence),
    .out_curl        (out_curl),
    .out_index_error (out_index_error)
  );

endmodule

// ===== hw/rtl/mgdc_scale.sv =====
// ----------------------------------------------------------------------------
// mgdc_scale
// Three-stage unit: magnitude of a face difference times an unsigned Q16.16
// factor (quartered in long mode), rounded to nearest (ties away from zero) to Q16.16.
// ----------------------------------------------------------------------------
module mgdc_scale (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_vld,
  input  logic signed [mgdc_pkg::DIFF_W-1:0]   in_d,
  input  logic        [31:0]                   in_k,
  input  logic                                 in_long,
  input  logic        [1:0]                    in_term,
  output logic                                 out_vld,
  output logic        [mgdc_pkg::PROD_W-1:0]   out_mag,
  output logic                                 out_neg,
  output logic        [1:0]                    out_term
);
  import mgdc_pkg::*;

  logic                vld1_r, vld2_r, vld3_r;
  logic [DIFF_W-1:0]   mag1_r;
  logic [HALF_W-1:0]   hi1_r, lo1_r;
  logic                neg1_r, neg2_r, neg3_r;
  logic                long1_r, long2_r;
  logic [1:0]          term1_r, term2_r, term3_r;
  logic [PROD_W-1:0]   a2_r, b2_r;
  logic [PROD_W-1:0]   x3_r;
  logic [MUL_W-1:0]    prod_a, prod_b;
  logic [PROD_W-1:0]   rnd;
  logic [PROD_W-1:0]   sum3;

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  // Stage 1: split sign and magnitude, split the factor in halves
  always_ff @(posedge clk) begin
    mag1_r  <= in_d[DIFF_W-1] ? DIFF_W'(-in_d) : DIFF_W'(in_d);
    neg1_r  <= in_d[DIFF_W-1];
    hi1_r   <= in_k[31:16];
    lo1_r   <= in_k[15:0];
    long1_r <= in_long;
    term1_r <= in_term;
  end

  // Stage 2: two partial products, rounding bias joins the low one
  assign prod_a = MUL_W'(mag1_r) * MUL_W'(hi1_r);
  assign prod_b = MUL_W'(mag1_r) * MUL_W'(lo1_r);
  assign rnd    = long1_r ? (PROD_W'(1) << (HALF_W + CURL_EXTRA - 1))
                          : (PROD_W'(1) << (HALF_W - 1));

  always_ff @(posedge clk) begin
    a2_r    <= PROD_W'(prod_a);
    b2_r    <= PROD_W'(prod_b) + rnd;
    neg2_r  <= neg1_r;
    long2_r <= long1_r;
    term2_r <= term1_r;
  end

  // Stage 3: combine halves and drop the fraction (and two more bits in long mode)
  assign sum3 = a2_r + (b2_r >> HALF_W);

  always_ff @(posedge clk) begin
    x3_r    <= long2_r ? (sum3 >> CURL_EXTRA) : sum3;
    neg3_r  <= neg2_r;
    term3_r <= term2_r;
  end

  assign out_vld  = vld3_r;
  assign out_mag  = x3_r;
  assign out_neg  = neg3_r;
  assign out_term = term3_r;

endmodule

// ===== hw/rtl/mgdc_dpath.sv =====
// ----------------------------------------------------------------------------
// mgdc_dpath
// Face stores, configuration registers, difference accumulators, scaling
// unit and result registers.
// ----------------------------------------------------------------------------
module mgdc_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mgdc_pkg::cmd_t                       cmd,
  output mgdc_pkg::status_t                    status,
  input  logic                                 cfg_we,
  input  logic        [mgdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [31:0]                   cfg_data,
  input  logic        [mgdc_pkg::IDX_W-1:0]    in_col,
  input  logic        [mgdc_pkg::IDX_W-1:0]    in_row,
  input  logic signed [mgdc_pkg::VALUE_W-1:0]  in_face_value,
  output logic signed [mgdc_pkg::VALUE_W-1:0]  out_divergence,
  output logic signed [mgdc_pkg::VALUE_W-1:0]  out_curl,
  output logic                                 out_index_error
);
  import mgdc_pkg::*;

  // Configuration
  logic [IDX_W-1:0] res_x_r, res_y_r;
  logic [31:0]      inv_x_r, inv_y_r;
  logic [IDX_W-1:0] rx, ry;

  // Query cell
  logic [IDX_W-1:0] col_r, row_r;
  logic             err_r;
  logic             in_err;
  logic [IDX_W-1:0] col_l, col_rt, row_b, row_t;
  logic [IDX_W-1:0] col_p1, row_p1;

  // Stores
  logic signed [VALUE_W-1:0] u_mem [STORE_DEPTH];
  logic signed [VALUE_W-1:0] v_mem [STORE_DEPTH];
  logic signed [VALUE_W-1:0] u_rdata_r, v_rdata_r;
  logic [IDX_W-1:0]          u_c, u_rw, v_c, v_rw;
  logic [ADDR_W-1:0]         u_addr, v_addr;
  logic                      u_we, v_we;
  logic                      rd_vld_r;
  logic [2:0]                rd_step_r;

  // Difference accumulators
  logic signed [DIFF_W-1:0]  ud_r, vd_r, uc_r, vc_r;
  logic signed [DIFF_W-1:0]  u_ext, v_ext;

  // Scaling
  logic signed [DIFF_W-1:0]  sc_d;
  logic [31:0]               sc_k;
  logic                      sc_long;
  logic                      sc_vld;
  logic [PROD_W-1:0]         sc_mag;
  logic                      sc_neg;
  logic [1:0]                sc_term;
  logic signed [ACC_W-1:0]   x_ext;
  logic signed [ACC_W-1:0]   div_r, curl_r;

  // Results
  logic signed [VALUE_W-1:0] out_div_r, out_curl_r;
  logic                      out_err_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_x_r <= IDX_W'(MAX_RES);
      res_y_r <= IDX_W'(MAX_RES);
      inv_x_r <= 32'h0001_0000;
      inv_y_r <= 32'h0001_0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RES_X: res_x_r <= cfg_data[IDX_W-1:0];
        CFG_RES_Y: res_y_r <= cfg_data[IDX_W-1:0];
        CFG_INV_X: inv_x_r <= cfg_data;
        CFG_INV_Y: inv_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clip resolution to the store size
  assign rx = (res_x_r > IDX_W'(MAX_RES)) ? IDX_W'(MAX_RES) : res_x_r;
  assign ry = (res_y_r > IDX_W'(MAX_RES)) ? IDX_W'(MAX_RES) : res_y_r;
  assign in_err = (in_col >= rx) || (in_row >= ry);

  // Latch the query cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= 1'b0;
    end else if (cmd.q_latch) begin
      err_r <= in_err;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_latch) begin
      col_r <= in_col;
      row_r <= in_row;
    end
  end

  assign status.q_err = err_r;

  // Neighbor cells, clamped at the grid edges
  assign col_p1 = col_r + IDX_W'(1);
  assign row_p1 = row_r + IDX_W'(1);
  assign col_l  = (col_r != '0) ? col_r - IDX_W'(1) : col_r;
  assign col_rt = (col_p1 < rx) ? col_p1 : col_r;
  assign row_b  = (row_r != '0) ? row_r - IDX_W'(1) : row_r;
  assign row_t  = (row_p1 < ry) ? row_p1 : row_r;

  // Pick the faces of this read step
  always_comb begin
    u_c  = col_r;
    u_rw = row_r;
    v_c  = col_r;
    v_rw = row_r;
    case (cmd.rd_step)
      STEP_BASE: begin
        u_c = col_r;  u_rw = row_r;
        v_c = col_r;  v_rw = row_r;
      end
      STEP_NEXT: begin
        u_c = col_p1; u_rw = row_r;
        v_c = col_r;  v_rw = row_p1;
      end
      STEP_HI_A: begin
        u_c = col_r;  u_rw = row_t;
        v_c = col_rt; v_rw = row_r;
      end
      STEP_HI_B: begin
        u_c = col_p1; u_rw = row_t;
        v_c = col_rt; v_rw = row_p1;
      end
      STEP_LO_A: begin
        u_c = col_r;  u_rw = row_b;
        v_c = col_l;  v_rw = row_r;
      end
      STEP_LO_B: begin
        u_c = col_p1; u_rw = row_b;
        v_c = col_l;  v_rw = row_p1;
      end
      default: ;
    endcase
  end

  // Store addresses: writes use the input item, reads the step's face
  assign u_we = cmd.wr_u && (in_col <= IDX_W'(MAX_RES)) && (in_row < IDX_W'(MAX_RES));
  assign v_we = cmd.wr_v && (in_col < IDX_W'(MAX_RES)) && (in_row <= IDX_W'(MAX_RES));

  always_comb begin
    if (cmd.wr_u) begin
      u_addr = ADDR_W'(in_row) * ADDR_W'(U_STRIDE) + ADDR_W'(in_col);
    end else begin
      u_addr = ADDR_W'(u_rw) * ADDR_W'(U_STRIDE) + ADDR_W'(u_c);
    end
    if (cmd.wr_v) begin
      v_addr = ADDR_W'(in_row) * ADDR_W'(V_STRIDE) + ADDR_W'(in_col);
    end else begin
      v_addr = ADDR_W'(v_rw) * ADDR_W'(V_STRIDE) + ADDR_W'(v_c);
    end
  end

  // Single-port face stores
  always_ff @(posedge clk) begin
    if (u_we) begin
      u_mem[u_addr] <= in_face_value;
    end else if (cmd.rd_en) begin
      u_rdata_r <= u_mem[u_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      v_mem[v_addr] <= in_face_value;
    end else if (cmd.rd_en) begin
      v_rdata_r <= v_mem[v_addr];
    end
  end

  // Track which step the read data belongs to
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_step_r <= cmd.rd_step;
  end

  // Fold face values into the four differences
  assign u_ext = {{(DIFF_W-VALUE_W){u_rdata_r[VALUE_W-1]}}, u_rdata_r};
  assign v_ext = {{(DIFF_W-VALUE_W){v_rdata_r[VALUE_W-1]}}, v_rdata_r};

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      case (rd_step_r) inside
        STEP_BASE: begin
          ud_r <= -u_ext;
          vd_r <= -v_ext;
        end
        STEP_NEXT: begin
          ud_r <= ud_r + u_ext;
          vd_r <= vd_r + v_ext;
        end
        STEP_HI_A: begin
          uc_r <= u_ext;
          vc_r <= v_ext;
        end
        STEP_HI_B: begin
          uc_r <= uc_r + u_ext;
          vc_r <= vc_r + v_ext;
        end
        STEP_LO_A, STEP_LO_B: begin
          uc_r <= uc_r - u_ext;
          vc_r <= vc_r - v_ext;
        end
        default: ;
      endcase
    end
  end

  // Feed one term a cycle to the scaling unit
  always_comb begin
    sc_d    = ud_r;
    sc_k    = inv_x_r;
    sc_long = 1'b0;
    case (cmd.sc_term)
      TERM_DIV_X: begin
        sc_d = ud_r; sc_k = inv_x_r; sc_long = 1'b0;
      end
      TERM_DIV_Y: begin
        sc_d = vd_r; sc_k = inv_y_r; sc_long = 1'b0;
      end
      TERM_CURL_X: begin
        sc_d = vc_r; sc_k = inv_x_r; sc_long = 1'b1;
      end
      TERM_CURL_Y: begin
        sc_d = uc_r; sc_k = inv_y_r; sc_long = 1'b1;
      end
      default: ;
    endcase
  end

  mgdc_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (cmd.sc_en),
    .in_d     (sc_d),
    .in_k     (sc_k),
    .in_long  (sc_long),
    .in_term  (cmd.sc_term),
    .out_vld  (sc_vld),
    .out_mag  (sc_mag),
    .out_neg  (sc_neg),
    .out_term (sc_term)
  );

  // Sum the rounded terms: divergence adds, curl subtracts the u term
  assign x_ext = ACC_W'(sc_mag);

  always_ff @(posedge clk) begin
    if (sc_vld) begin
      case (sc_term)
        TERM_DIV_X:  div_r  <= sc_neg ? -x_ext : x_ext;
        TERM_DIV_Y:  div_r  <= sc_neg ? div_r - x_ext : div_r + x_ext;
        TERM_CURL_X: curl_r <= sc_neg ? -x_ext : x_ext;
        TERM_CURL_Y: curl_r <= sc_neg ? curl_r + x_ext : curl_r - x_ext;
        default: ;
      endcase
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_div_r  <= err_r ? '0 : sat_val(div_r);
      out_curl_r <= err_r ? '0 : sat_val(curl_r);
      out_err_r  <= err_r;
    end
  end

  assign out_divergence  = out_div_r;
  assign out_curl        = out_curl_r;
  assign out_index_error = out_err_r;

endmodule

// ===== hw/rtl/mgdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mgdc_ctrl
// Sequencer: accepts items, steps a query through face reads, scaling and
// result load, and raises the result strobe.
// ----------------------------------------------------------------------------
module mgdc_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [mgdc_pkg::KIND_W-1:0]      in_kind,
  input  mgdc_pkg::status_t                status,
  output mgdc_pkg::cmd_t                   cmd,
  output logic                             busy,
  output logic                             out_valid
);
  import mgdc_pkg::*;

  localparam logic [2:0] LAST_TERM  = 3'(TERM_CURL_Y);
  localparam logic [2:0] LAST_DRAIN = 3'(SCALE_DEPTH - 1);

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       out_valid_r;

  // State and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= cmd.out_load;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_kind)
            KIND_WR_U: cmd.wr_u = 1'b1;
            KIND_WR_V: cmd.wr_v = 1'b1;
            KIND_QUERY: begin
              cmd.q_latch = 1'b1;
              state_nxt   = ST_CHECK;
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        cnt_nxt   = '0;
        state_nxt = status.q_err ? ST_EMIT : ST_READ;
      end
      ST_READ: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_step = cnt_r;
        if (cnt_r == STEP_LO_B) begin
          state_nxt = ST_SETTLE;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      ST_SETTLE: begin
        cnt_nxt   = '0;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.sc_en   = 1'b1;
        cmd.sc_term = cnt_r[1:0];
        if (cnt_r == LAST_TERM) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      ST_DRAIN: begin
        if (cnt_r == LAST_DRAIN) begin
          state_nxt = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      ST_EMIT: begin
        cmd.out_load = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/mgdc_checker.sv =====
// ----------------------------------------------------------------------------
// mgdc_checker
// Port-level checks of the MAC grid block, bound to the top level.
// ----------------------------------------------------------------------------
`include "mac_grid_divergence_curl_assert.svh"

module mgdc_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 start,
  input logic                                 busy,
  input logic        [mgdc_pkg::KIND_W-1:0]   in_kind,
  input logic                                 out_valid,
  input logic signed [mgdc_pkg::VALUE_W-1:0]  out_divergence,
  input logic signed [mgdc_pkg::VALUE_W-1:0]  out_curl,
  input logic                                 out_index_error
);
  import mgdc_pkg::*;

  // An accepted query holds the block busy
  `MGDC_CHK_NEXT(a_query_busy, start && !busy && in_kind == KIND_QUERY, busy)

  // Writes and unused kinds complete in the accept cycle
  `MGDC_CHK_NEXT(a_write_idle, start && !busy && in_kind != KIND_QUERY, !busy)

  // The result beat follows the end of a query and lasts one cycle
  `MGDC_CHK_SAME(a_beat_after_busy, $fell(busy), out_valid)
  `MGDC_CHK_NEXT(a_beat_single, out_valid, !out_valid)

  // An out-of-range beat carries zero values
  `MGDC_CHK_SAME(a_err_zero, out_valid && out_index_error,
                 out_divergence == '0 && out_curl == '0)

endmodule

bind mac_grid_divergence_curl mgdc_checker u_mgdc_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the MAC grid divergence/curl block.
// Loads face velocities, queries cells under a series of grid sizes and
// spacing factors, and compares every result beat with a bit-exact
// prediction of divergence, curl and the range flag.
// ---------------------------------------------------------------------------
module tb;
  import mgdc_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int TAIL_CYCLES  = 24;
  localparam int ITEM_TARGET  = 450;
  localparam int PHASES       = 8;

  typedef struct {
    logic signed [VALUE_W-1:0] divergence;
    logic signed [VALUE_W-1:0] curl;
    logic                      index_error;
  } cell_result_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    int                col;
    int                row;
  } face_ref_t;

  typedef enum {VAL_WIDE, VAL_EXTREME, VAL_NARROW} value_style_t;

  // Mirror of the face stores and registers; predicts and checks result beats
  class div_curl_board;
    logic [IDX_W-1:0]          res_x = 7'd64;
    logic [IDX_W-1:0]          res_y = 7'd64;
    logic [31:0]               inv_x = 32'h0001_0000;
    logic [31:0]               inv_y = 32'h0001_0000;
    logic signed [VALUE_W-1:0] u_face [STORE_DEPTH];
    logic signed [VALUE_W-1:0] v_face [STORE_DEPTH];
    cell_result_t              cell_results_due [$];
    int                        mismatches = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_RES_X: res_x = data[IDX_W-1:0];
        CFG_RES_Y: res_y = data[IDX_W-1:0];
        CFG_INV_X: inv_x = data;
        CFG_INV_Y: inv_y = data;
      endcase
    endfunction

    function longint u_at(int c, int w);
      return longint'(u_face[w * U_STRIDE + c]);
    endfunction

    function longint v_at(int c, int w);
      return longint'(v_face[w * V_STRIDE + c]);
    endfunction

    // Scale a difference by an unsigned Q16.16 factor, round half away from zero
    function longint scaled(longint d, logic [31:0] k, int shift);
      logic [95:0] mag;
      logic [95:0] prod;
      mag  = (d < 0) ? 96'(-d) : 96'(d);
      prod = (mag * {64'd0, k} + (96'd1 << (shift - 1))) >> shift;
      return (d < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function logic signed [VALUE_W-1:0] clip(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[VALUE_W-1:0];
    endfunction

    // Apply one accepted item; queue the result beat a query will give
    function void note_item(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] col,
                            logic [IDX_W-1:0] row, logic signed [VALUE_W-1:0] value);
      int           c, w, rx, ry, l, r, b, t;
      longint       div_sum, dv, du;
      cell_result_t res;
      c = int'(col);
      w = int'(row);
      case (kind)
        KIND_WR_U: begin
          if (c <= MAX_RES && w < MAX_RES) u_face[w * U_STRIDE + c] = value;
        end
        KIND_WR_V: begin
          if (c < MAX_RES && w <= MAX_RES) v_face[w * V_STRIDE + c] = value;
        end
        KIND_QUERY: begin
          rx = (res_x > MAX_RES) ? MAX_RES : res_x;
          ry = (res_y > MAX_RES) ? MAX_RES : res_y;
          if (c >= rx || w >= ry) begin
            res = '{32'sd0, 32'sd0, 1'b1};
          end else begin
            div_sum = scaled(u_at(c + 1, w) - u_at(c, w), inv_x, 16)
                    + scaled(v_at(c, w + 1) - v_at(c, w), inv_y, 16);
            // clamp neighbor cells at the grid edges
            l = (c > 0) ? c - 1 : c;
            r = (c + 1 < rx) ? c + 1 : c;
            b = (w > 0) ? w - 1 : w;
            t = (w + 1 < ry) ? w + 1 : w;
            dv = (v_at(r, w) + v_at(r, w + 1)) - (v_at(l, w) + v_at(l, w + 1));
            du = (u_at(c, t) + u_at(c + 1, t)) - (u_at(c, b) + u_at(c + 1, b));
            res.divergence  = clip(div_sum);
            res.curl        = clip(scaled(dv, inv_x, 18) - scaled(du, inv_y, 18));
            res.index_error = 1'b0;
          end
          cell_results_due.push_back(res);
        end
        default: ;
      endcase
    endfunction

    // Compare one result beat with the oldest pending query
    function void check_beat(logic signed [VALUE_W-1:0] divergence,
                             logic signed [VALUE_W-1:0] curl, logic index_error);
      cell_result_t want;
      if (cell_results_due.size() == 0) begin
        $error("result beat with no query pending");
        mismatches++;
        return;
      end
      want = cell_results_due.pop_front();
      if (divergence !== want.divergence) begin
        $error("divergence: expected %0d, got %0d", want.divergence, divergence);
        mismatches++;
      end
      if (curl !== want.curl) begin
        $error("curl: expected %0d, got %0d", want.curl, curl);
        mismatches++;
      end
      if (index_error !== want.index_error) begin
        $error("index_error: expected %0b, got %0b", want.index_error, index_error);
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [KIND_W-1:0]         in_kind = '0;
  logic [IDX_W-1:0]          in_col = '0;
  logic [IDX_W-1:0]          in_row = '0;
  logic signed [VALUE_W-1:0] in_face_value = '0;
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_divergence;
  logic signed [VALUE_W-1:0] out_curl;
  logic                      out_index_error;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [31:0]               cfg_data = '0;

  div_curl_board grid_model = new();
  bit            u_done [STORE_DEPTH];
  bit            v_done [STORE_DEPTH];
  int            gap_pct = 0;
  int            items_sent = 0;
  int            phase_end = 0;
  int unsigned   cycle_count = 0;

  mac_grid_divergence_curl dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_col          (in_col),
    .in_row          (in_row),
    .in_face_value   (in_face_value),
    .out_valid       (out_valid),
    .out_divergence  (out_divergence),
    .out_curl        (out_curl),
    .out_index_error (out_index_error),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Check each result beat at the edge that ends it
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      grid_model.check_beat(out_divergence, out_curl, out_index_error);
    end
  end

  function automatic int cells_in_use(logic [IDX_W-1:0] r);
    return (r > MAX_RES) ? MAX_RES : r;
  endfunction

  function automatic bit face_written(face_ref_t f);
    if (f.kind == KIND_WR_U) return u_done[f.row * U_STRIDE + f.col];
    return v_done[f.row * V_STRIDE + f.col];
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value(value_style_t style);
    case (style)
      VAL_EXTREME: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      VAL_NARROW:  return 32'($urandom_range(0, 2097151)) - 32'd1048576;
      default:     return $urandom;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_res();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return 7'd0;
    if (roll < 15) return 7'($urandom_range(65, 127));
    if (roll < 25) return 7'd1;
    if (roll < 35) return 7'd64;
    return 7'($urandom_range(2, 12));
  endfunction

  function automatic logic [31:0] pick_spacing();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return 32'd0;
    if (roll < 10) return 32'hFFFF_FFFF;
    if (roll < 25) return 32'h0001_0000;
    if (roll < 75) return 32'($urandom_range(0, 32'h0004_0000));
    return $urandom;
  endfunction

  // Pause the sender with start low, with noise on the item fields
  task automatic pause_sender(int n);
    repeat (n) begin
      @(negedge clk);
      start         = 1'b0;
      in_kind       = 2'($urandom);
      in_col        = 7'($urandom);
      in_row        = 7'($urandom);
      in_face_value = $urandom;
    end
  endtask

  // Offer one item and hold it until the block takes the beat
  task automatic send_item(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] col,
                           logic [IDX_W-1:0] row, logic signed [VALUE_W-1:0] value);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) pause_sender($urandom_range(1, 17));
    @(negedge clk);
    start         = 1'b1;
    in_kind       = kind;
    in_col        = col;
    in_row        = row;
    in_face_value = value;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    grid_model.note_item(kind, col, row, value);
    items_sent++;
    if (kind == KIND_WR_U && col <= MAX_RES && row < MAX_RES) u_done[row * U_STRIDE + col] = 1'b1;
    if (kind == KIND_WR_V && col < MAX_RES && row <= MAX_RES) v_done[row * V_STRIDE + col] = 1'b1;
  endtask

  // Drop start and wait until every pending query has returned
  task automatic wait_results();
    @(negedge clk);
    start = 1'b0;
    while (grid_model.cell_results_due.size() != 0) @(negedge clk);
  endtask

  task automatic quiesce();
    wait_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    grid_model.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Reprogram the grid once the block is idle; upper bits of res writes are noise
  task automatic set_grid(logic [IDX_W-1:0] rx, logic [IDX_W-1:0] ry,
                          logic [31:0] kx, logic [31:0] ky);
    quiesce();
    write_reg(CFG_RES_X, {25'($urandom), rx});
    write_reg(CFG_RES_Y, {25'($urandom), ry});
    write_reg(CFG_INV_X, kx);
    write_reg(CFG_INV_Y, ky);
  endtask

  // Faces a query of cell (c, w) reads under the current resolution
  task automatic cell_faces(int c, int w, output face_ref_t refs [12]);
    int rx, ry, l, r, b, t;
    rx = cells_in_use(grid_model.res_x);
    ry = cells_in_use(grid_model.res_y);
    l = (c > 0) ? c - 1 : c;
    r = (c + 1 < rx) ? c + 1 : c;
    b = (w > 0) ? w - 1 : w;
    t = (w + 1 < ry) ? w + 1 : w;
    refs[0]  = '{KIND_WR_U, c,     w};
    refs[1]  = '{KIND_WR_U, c + 1, w};
    refs[2]  = '{KIND_WR_V, c,     w};
    refs[3]  = '{KIND_WR_V, c,     w + 1};
    refs[4]  = '{KIND_WR_V, r,     w};
    refs[5]  = '{KIND_WR_V, r,     w + 1};
    refs[6]  = '{KIND_WR_V, l,     w};
    refs[7]  = '{KIND_WR_V, l,     w + 1};
    refs[8]  = '{KIND_WR_U, c,     t};
    refs[9]  = '{KIND_WR_U, c + 1, t};
    refs[10] = '{KIND_WR_U, c,     b};
    refs[11] = '{KIND_WR_U, c + 1, b};
  endtask

  // Rewrite some faces of an in-range cell, fill the unwritten ones, then query it
  task automatic query_cell(int c, int w, value_style_t style, int rewrites);
    face_ref_t refs [12];
    int        k;
    cell_faces(c, w, refs);
    repeat (rewrites) begin
      k = $urandom_range(11);
      send_item(refs[k].kind, IDX_W'(refs[k].col), IDX_W'(refs[k].row), pick_value(style));
    end
    foreach (refs[i]) begin
      if (!face_written(refs[i])) begin
        send_item(refs[i].kind, IDX_W'(refs[i].col), IDX_W'(refs[i].row),
                  pick_value(style));
      end
    end
    send_item(KIND_QUERY, IDX_W'(c), IDX_W'(w), $urandom);
  endtask

  task automatic query_outside(int rx, int ry);
    if ($urandom_range(1)) send_item(KIND_QUERY, 7'($urandom_range(rx, 127)), 7'($urandom), $urandom);
    else send_item(KIND_QUERY, 7'($urandom), 7'($urandom_range(ry, 127)), $urandom);
  endtask

  task automatic random_sequence();
    int           rx, ry, roll, c, w;
    value_style_t style;
    rx   = cells_in_use(grid_model.res_x);
    ry   = cells_in_use(grid_model.res_y);
    roll = $urandom_range(99);
    if (roll < 65 && rx > 0 && ry > 0) begin
      // favor the grid edges where neighbors clamp
      c = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 0 : rx - 1) : $urandom_range(rx - 1);
      w = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 0 : ry - 1) : $urandom_range(ry - 1);
      case ($urandom_range(9)) inside
        0, 1:    style = VAL_EXTREME;
        2, 3, 4: style = VAL_NARROW;
        default: style = VAL_WIDE;
      endcase
      query_cell(c, w, style, $urandom_range(3));
    end else if (roll < 78) begin
      query_outside(rx, ry);
    end else if (roll < 90) begin
      // stray write, often outside the store
      send_item($urandom_range(1) ? KIND_WR_U : KIND_WR_V, 7'($urandom), 7'($urandom),
                $urandom);
    end else if (roll < 95) begin
      send_item(KIND_UNUSED, 7'($urandom), 7'($urandom), $urandom);
    end else begin
      wait_results();
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n   = 1'b1;
    gap_pct = 20;

    // Ignored kind and writes that miss the store
    send_item(KIND_UNUSED, 7'd127, 7'd127, 32'sh7FFF_FFFF);
    send_item(KIND_WR_U, 7'd65, 7'd0, $urandom);
    send_item(KIND_WR_U, 7'd0, 7'd64, $urandom);
    send_item(KIND_WR_V, 7'd64, 7'd0, $urandom);
    send_item(KIND_WR_V, 7'd0, 7'd65, $urandom);
    send_item(KIND_WR_U, 7'd127, 7'd127, $urandom);
    // Last face of each store
    send_item(KIND_WR_U, 7'd64, 7'd63, 32'sh8000_0000);
    send_item(KIND_WR_V, 7'd63, 7'd64, 32'sh7FFF_FFFF);
    // Queries outside the grid
    send_item(KIND_QUERY, 7'd64, 7'd0, '0);
    send_item(KIND_QUERY, 7'd0, 7'd64, '0);
    send_item(KIND_QUERY, 7'd127, 7'd127, '1);
    // Corners at full range, then saturation both ways
    query_cell(63, 63, VAL_EXTREME, 0);
    query_cell(0, 0, VAL_EXTREME, 0);
    send_item(KIND_WR_U, 7'd1, 7'd0, 32'sh7FFF_FFFF);
    send_item(KIND_WR_U, 7'd0, 7'd0, 32'sh8000_0000);
    send_item(KIND_QUERY, 7'd0, 7'd0, '0);
    send_item(KIND_WR_U, 7'd1, 7'd0, 32'sh8000_0000);
    send_item(KIND_WR_U, 7'd0, 7'd0, 32'sh7FFF_FFFF);
    send_item(KIND_QUERY, 7'd0, 7'd0, '0);
    // One-cell grid with the largest spacing factors
    set_grid(7'd1, 7'd1, '1, '1);
    query_cell(0, 0, VAL_EXTREME, 2);
    send_item(KIND_QUERY, 7'd1, 7'd0, '0);
    // Zero resolution, zero spacing
    set_grid(7'd0, 7'd5, '0, '0);
    send_item(KIND_QUERY, 7'd0, 7'd0, '0);
    // Resolution above the store size acts as the store size
    set_grid(7'd127, 7'd100, '0, 32'h0001_0000);
    query_cell(63, 63, VAL_WIDE, 1);
    send_item(KIND_QUERY, 7'd64, 7'd10, '0);
    // Two-by-two grid, curl terms at full scale
    set_grid(7'd2, 7'd2, '1, '1);
    query_cell(0, 0, VAL_EXTREME, 4);
    query_cell(1, 1, VAL_EXTREME, 4);

    // Random phases share the remaining items; the last one runs without gaps
    for (int p = 0; p < PHASES; p++) begin
      set_grid(pick_res(), pick_res(), pick_spacing(), pick_spacing());
      case ($urandom_range(3))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        2:       gap_pct = 30;
        default: gap_pct = 60;
      endcase
      if (p == PHASES - 1) gap_pct = 0;
      phase_end = items_sent + (ITEM_TARGET - items_sent) / (PHASES - p);
      while (items_sent < phase_end) random_sequence();
    end

    wait_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (grid_model.mismatches == 0 && grid_model.cell_results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mgdc_pkg.sv
hw/rtl/mgdc_scale.sv
hw/rtl/mgdc_dpath.sv
hw/rtl/mgdc_ctrl.sv
hw/rtl/mac_grid_divergence_curl.sv
hw/rtl/mgdc_checker.sv
verif/tb.sv
